// ===== rtl/mmbt_pkg.sv =====
// Package for the pointer tracking block: kinds, register indexes, states,
// and constants for reset, alignment, events and unit widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mmbt_pkg;

   typedef enum logic [2:0] {
      KIND_PACKET   = 3'd0,
      KIND_READ_POS = 3'd1,
      KIND_SET_POS  = 3'd2,
      KIND_PRESS    = 3'd3,
      KIND_RELEASE  = 3'd4,
      KIND_MOTION   = 3'd5,
      KIND_RESET    = 3'd6,
      KIND_NONE     = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      REG_MIN_X  = 3'd0,
      REG_MAX_X  = 3'd1,
      REG_MIN_Y  = 3'd2,
      REG_MAX_Y  = 3'd3,
      REG_WIDTH  = 3'd4,
      REG_HEIGHT = 3'd5,
      REG_TEXT   = 3'd6,
      REG_SPARE  = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_DIV_X,
      ST_MUL_Y,
      ST_DIV_Y,
      ST_DONE
   } state_type;

   localparam logic [15:0] MAX_X_RESET  = 16'd639;
   localparam logic [15:0] MAX_Y_RESET  = 16'd199;
   localparam logic [11:0] WIDTH_RESET  = 12'd80;
   localparam logic [11:0] HEIGHT_RESET = 12'd25;
   localparam logic [15:0] ALIGN_BITS   = 16'h0007;
   localparam logic [6:0]  MOVED_EVENT  = 7'h01;
   // Operand and counter widths of the serial scaling unit.
   localparam int unsigned PROD_W = 33;
   localparam int unsigned DIV_W  = 17;
   localparam int unsigned CNT_W  = 6;

endpackage
`default_nettype wire

// ===== rtl/mouse_motion_button_tracker_top.sv =====
// Top level of the pointer tracking block: state, handshakes and a bit-serial
// multiply and divide unit for coordinate scaling. Uses mmbt_pkg.
// Words without scaling: the result is registered and valid in the cycle after acceptance.
// Scaled words: x then y each go through a shift-add multiply and a restoring divide,
// then ST_DONE sets the result. No word is accepted while busy or a result waits.
// Reset is synchronous and active high; it restores all but the payload registers.
`timescale 1ns / 1ps
`default_nettype none
module mouse_motion_button_tracker_top #(
   parameter int unsigned BUTTON_COUNT = 3
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_kind,
   input  wire logic [7:0]  req_packet_flags,
   input  wire logic [7:0]  req_delta_x_byte,
   input  wire logic [7:0]  req_delta_y_byte,
   input  wire logic [15:0] req_pos_x,
   input  wire logic [15:0] req_pos_y,
   input  wire logic [2:0]  req_button_bits,
   input  wire logic [1:0]  req_button_index,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [6:0]       rsp_event_mask,
   output logic [2:0]       rsp_report_buttons,
   output logic [15:0]      rsp_report_x,
   output logic [15:0]      rsp_report_y,
   output logic [15:0]      rsp_report_count,
   output logic signed [15:0] rsp_motion_x,
   output logic signed [15:0] rsp_motion_y,
   output logic             rsp_bad_index,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int unsigned PW = mmbt_pkg::PROD_W;
   localparam int unsigned DW = mmbt_pkg::DIV_W;
   localparam int unsigned CW = mmbt_pkg::CNT_W;

   // Configuration registers.
   logic [15:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic [11:0] width_ff, height_ff;
   logic        text_ff;
   // Tracking state.
   logic [15:0] cur_x_ff, cur_y_ff, hmot_ff, vmot_ff;
   logic [2:0]  held_ff;
   logic [15:0] pcnt_ff [3];
   logic [15:0] rcnt_ff [3];
   logic [31:0] pspot_ff [3];
   logic [31:0] rspot_ff [3];

   // Work registers.
   mmbt_pkg::state_type state_ff, state_in;
   logic        to_screen_ff;          // direction of scaling
   logic [15:0] src_y_ff;              // pending y operand
   logic [15:0] lo_y_ff;
   logic [PW-1:0] acc_ff;              // running product
   logic [DW-1:0] mcand_ff;            // multiplicand: shifts out low bit
   logic [PW-1:0] madd_ff;             // shifted addend
   logic [DW-1:0] divisor_ff;
   logic [PW-1:0] quot_ff;
   logic [DW-1:0] rem_ff;
   logic [CW-1:0] cnt_ff;
   logic [15:0]   base_ff;             // added to the quotient (virtual min)

   // Result register.
   logic        rv_ff;
   logic [6:0]  ev_ff;
   logic [2:0]  rb_ff;
   logic [15:0] rx_ff, ry_ff, rc_ff, mx_ff, my_ff;
   logic        bad_ff;

   // Result fields and unit operands for the word being accepted.
   logic [6:0]    ev_in;
   logic [2:0]    rb_in;
   logic [15:0]   rc_in, mx_in, my_in;
   logic          bad_in;
   logic [DW-1:0] mcand_in;
   logic [15:0]   src_y_in;
   logic          start_unit;

   mmbt_pkg::kind_type kind;
   assign kind = mmbt_pkg::kind_type'(req_kind);

   assign req_ready = (state_ff == mmbt_pkg::ST_IDLE) && !rv_ff;
   assign csr_ready = 1'b1;
   wire take = req_valid && req_ready;

   assign rsp_valid          = rv_ff;
   assign rsp_event_mask     = ev_ff;
   assign rsp_report_buttons = rb_ff;
   assign rsp_report_x       = rx_ff;
   assign rsp_report_y       = ry_ff;
   assign rsp_report_count   = rc_ff;
   assign rsp_motion_x       = mx_ff;
   assign rsp_motion_y       = my_ff;
   assign rsp_bad_index      = bad_ff;

   // Span and resolution for each axis.
   function automatic logic [DW-1:0] span_f(input logic [15:0] lo, input logic [15:0] hi);
      logic [DW-1:0] s;
      s = (hi >= lo) ? ({1'b0, hi} - {1'b0, lo} + 17'd1) : 17'd1;
      return s;
   endfunction

   function automatic logic [DW-1:0] res_f(input logic [11:0] sz, input logic txt);
      logic [DW-1:0] r;
      r = txt ? {2'b00, sz, 3'b000} : {5'd0, sz};
      return (r == '0) ? 17'd1 : r;
   endfunction

   wire [DW-1:0] span_x = span_f(min_x_ff, max_x_ff);
   wire [DW-1:0] span_y = span_f(min_y_ff, max_y_ff);
   wire [DW-1:0] res_x  = res_f(width_ff, text_ff);
   wire [DW-1:0] res_y  = res_f(height_ff, text_ff);

   wire [1:0] idx = req_button_index;
   wire idx_bad = ({30'd0, idx} >= BUTTON_COUNT) || (idx == 2'd3);
   wire [15:0] dx = {{8{req_packet_flags[4]}}, req_delta_x_byte};
   wire [15:0] dy = {{8{req_packet_flags[5]}}, req_delta_y_byte};

   // Restoring divide step: one quotient bit a cycle.
   wire [DW:0]   rem_sh  = {rem_ff, quot_ff[PW-1]};
   wire          rem_ge  = rem_sh >= {1'b0, divisor_ff};
   wire [DW:0]   rem_nx  = rem_ge ? rem_sh - {1'b0, divisor_ff} : rem_sh;
   wire [PW-1:0] quot_nx = {quot_ff[PW-2:0], rem_ge};
   wire [15:0]   scaled  = base_ff + quot_nx[15:0];

   // Result fields of the offered word and whether it needs the scaling unit.
   always_comb begin
      ev_in = '0; rb_in = '0; rc_in = '0; mx_in = '0; my_in = '0; bad_in = 1'b0;
      mcand_in = '0; src_y_in = '0; start_unit = 1'b0;
      unique case (kind)
         mmbt_pkg::KIND_PACKET: begin
            ev_in = mmbt_pkg::MOVED_EVENT;
            for (int i = 0; i < 3; i++) begin
               if (i < BUTTON_COUNT) begin
                  if (req_button_bits[i] && !held_ff[i]) ev_in[2*i+1] = 1'b1;
                  else if (!req_button_bits[i] && held_ff[i]) ev_in[2*i+2] = 1'b1;
               end
            end
            rb_in = req_button_bits;
            mcand_in = {1'b0, req_pos_x};
            src_y_in = req_pos_y;
            start_unit = 1'b1;
         end
         mmbt_pkg::KIND_READ_POS: begin
            rb_in = held_ff;
            mcand_in = {1'b0, cur_x_ff};
            src_y_in = cur_y_ff;
            start_unit = 1'b1;
         end
         mmbt_pkg::KIND_SET_POS: begin
            mcand_in = (req_pos_x >= min_x_ff) ? {1'b0, req_pos_x - min_x_ff} : '0;
            src_y_in = (req_pos_y >= min_y_ff) ? req_pos_y - min_y_ff : '0;
            start_unit = 1'b1;
         end
         mmbt_pkg::KIND_PRESS: begin
            rb_in = held_ff;
            bad_in = idx_bad;
            if (!idx_bad) begin
               rc_in = pcnt_ff[idx];
               mcand_in = {1'b0, pspot_ff[idx][15:0]};
               src_y_in = pspot_ff[idx][31:16];
               start_unit = 1'b1;
            end
         end
         mmbt_pkg::KIND_RELEASE: begin
            rb_in = held_ff;
            bad_in = idx_bad;
            if (!idx_bad) begin
               rc_in = rcnt_ff[idx];
               mcand_in = {1'b0, rspot_ff[idx][15:0]};
               src_y_in = rspot_ff[idx][31:16];
               start_unit = 1'b1;
            end
         end
         mmbt_pkg::KIND_MOTION: begin
            mx_in = hmot_ff; my_in = vmot_ff;
         end
         mmbt_pkg::KIND_RESET: rc_in = 16'(BUTTON_COUNT);
         default: ;
      endcase
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mmbt_pkg::ST_IDLE:  if (take && start_unit) state_in = mmbt_pkg::ST_MUL_X;
         mmbt_pkg::ST_MUL_X: if (cnt_ff == CW'(DW - 1)) state_in = mmbt_pkg::ST_DIV_X;
         mmbt_pkg::ST_DIV_X: if (cnt_ff == CW'(PW - 1)) state_in = mmbt_pkg::ST_MUL_Y;
         mmbt_pkg::ST_MUL_Y: if (cnt_ff == CW'(DW - 1)) state_in = mmbt_pkg::ST_DIV_Y;
         mmbt_pkg::ST_DIV_Y: if (cnt_ff == CW'(PW - 1)) state_in = mmbt_pkg::ST_DONE;
         mmbt_pkg::ST_DONE:  state_in = mmbt_pkg::ST_IDLE;
         default:            state_in = mmbt_pkg::ST_IDLE;
      endcase
   end

   // Main datapath and state.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff <= '0; max_x_ff <= mmbt_pkg::MAX_X_RESET;
         min_y_ff <= '0; max_y_ff <= mmbt_pkg::MAX_Y_RESET;
         width_ff <= mmbt_pkg::WIDTH_RESET; height_ff <= mmbt_pkg::HEIGHT_RESET;
         text_ff <= 1'b1;
         cur_x_ff <= '0; cur_y_ff <= '0; hmot_ff <= '0; vmot_ff <= '0;
         held_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            pcnt_ff[i] <= '0; rcnt_ff[i] <= '0;
            pspot_ff[i] <= '0; rspot_ff[i] <= '0;
         end
         state_ff <= mmbt_pkg::ST_IDLE;
         rv_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;

         // Result valid: set by a word without scaling or at the end of the unit.
         priority if (take && !start_unit) rv_ff <= 1'b1;
         else if (state_ff == mmbt_pkg::ST_DONE) rv_ff <= 1'b1;
         else if (rv_ff && rsp_ready) rv_ff <= 1'b0;

         // Configuration words.
         if (csr_valid) begin
            unique case (mmbt_pkg::reg_index_type'(csr_index))
               mmbt_pkg::REG_MIN_X:  min_x_ff <= text_ff ? csr_data & ~mmbt_pkg::ALIGN_BITS
                                                         : csr_data;
               mmbt_pkg::REG_MAX_X:  max_x_ff <= text_ff ? csr_data | mmbt_pkg::ALIGN_BITS
                                                         : csr_data;
               mmbt_pkg::REG_MIN_Y:  min_y_ff <= text_ff ? csr_data & ~mmbt_pkg::ALIGN_BITS
                                                         : csr_data;
               mmbt_pkg::REG_MAX_Y:  max_y_ff <= text_ff ? csr_data | mmbt_pkg::ALIGN_BITS
                                                         : csr_data;
               mmbt_pkg::REG_WIDTH:  width_ff <= csr_data[11:0];
               mmbt_pkg::REG_HEIGHT: height_ff <= csr_data[11:0];
               mmbt_pkg::REG_TEXT:   text_ff <= csr_data[0];
               mmbt_pkg::REG_SPARE:  ;
               default: ;
            endcase
         end

         // Counter steps for the serial unit; it rests at zero when idle.
         if (state_ff == mmbt_pkg::ST_MUL_X || state_ff == mmbt_pkg::ST_MUL_Y) begin
            cnt_ff <= (cnt_ff == CW'(DW - 1)) ? '0 : cnt_ff + CW'(1);
         end else if (state_ff == mmbt_pkg::ST_DIV_X || state_ff == mmbt_pkg::ST_DIV_Y) begin
            cnt_ff <= (cnt_ff == CW'(PW - 1)) ? '0 : cnt_ff + CW'(1);
         end

         // Set position stores the screen coordinates that the unit gives.
         if (state_ff == mmbt_pkg::ST_DIV_Y && cnt_ff == CW'(PW - 1) && to_screen_ff) begin
            cur_y_ff <= quot_nx[15:0];
         end
         if (state_ff == mmbt_pkg::ST_DIV_X && cnt_ff == CW'(PW - 1) && to_screen_ff) begin
            cur_x_ff <= quot_nx[15:0];
         end

         // Item acceptance.
         if (take) begin
            unique case (kind)
               mmbt_pkg::KIND_PACKET: begin
                  hmot_ff <= hmot_ff + dx;
                  vmot_ff <= vmot_ff + dy;
                  cur_x_ff <= req_pos_x; cur_y_ff <= req_pos_y;
                  for (int i = 0; i < 3; i++) begin
                     if (i < BUTTON_COUNT) begin
                        if (req_button_bits[i] && !held_ff[i]) begin
                           pcnt_ff[i] <= pcnt_ff[i] + 16'd1;
                           pspot_ff[i] <= {req_pos_y, req_pos_x};
                        end else if (!req_button_bits[i] && held_ff[i]) begin
                           rcnt_ff[i] <= rcnt_ff[i] + 16'd1;
                           rspot_ff[i] <= {req_pos_y, req_pos_x};
                        end
                     end
                  end
                  held_ff <= req_button_bits;
               end
               mmbt_pkg::KIND_PRESS:
                  if (!idx_bad) pcnt_ff[idx] <= '0;
               mmbt_pkg::KIND_RELEASE:
                  if (!idx_bad) rcnt_ff[idx] <= '0;
               mmbt_pkg::KIND_MOTION: begin
                  hmot_ff <= '0; vmot_ff <= '0;
               end
               mmbt_pkg::KIND_RESET: begin
                  held_ff <= '0;
                  hmot_ff <= '0; vmot_ff <= '0;
                  min_x_ff <= '0; max_x_ff <= mmbt_pkg::MAX_X_RESET;
                  min_y_ff <= '0; max_y_ff <= mmbt_pkg::MAX_Y_RESET;
                  for (int i = 0; i < 3; i++) begin
                     pcnt_ff[i] <= '0; rcnt_ff[i] <= '0;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // Payload registers of the serial unit and the result word.
   always_ff @(posedge clock) begin
      if (take) begin
         ev_ff  <= ev_in; rb_ff <= rb_in; rx_ff <= '0; ry_ff <= '0; rc_ff <= rc_in;
         mx_ff  <= mx_in; my_ff <= my_in; bad_ff <= bad_in;
         to_screen_ff <= (kind == mmbt_pkg::KIND_SET_POS);
         acc_ff <= '0;
         mcand_ff <= mcand_in;
         src_y_ff <= src_y_in;
         // Multiplier and divisor per direction.
         madd_ff <= PW'(kind == mmbt_pkg::KIND_SET_POS ? res_x : span_x);
         divisor_ff <= (kind == mmbt_pkg::KIND_SET_POS) ? span_x : res_x;
         base_ff <= min_x_ff;
         lo_y_ff <= min_y_ff;
      end else begin
         unique case (state_ff)
            mmbt_pkg::ST_MUL_X, mmbt_pkg::ST_MUL_Y: begin
               // Shift-add: one multiplicand bit a cycle.
               if (mcand_ff[0]) acc_ff <= acc_ff + madd_ff;
               mcand_ff <= mcand_ff >> 1;
               madd_ff <= madd_ff << 1;
               if (cnt_ff == CW'(DW - 1)) begin
                  quot_ff <= mcand_ff[0] ? acc_ff + madd_ff : acc_ff;
                  rem_ff <= '0;
               end
            end
            mmbt_pkg::ST_DIV_X, mmbt_pkg::ST_DIV_Y: begin
               quot_ff <= quot_nx;
               rem_ff <= rem_nx[DW-1:0];
               if (cnt_ff == CW'(PW - 1)) begin
                  if (state_ff == mmbt_pkg::ST_DIV_X) begin
                     // Post x and load the y operands.
                     if (!to_screen_ff) rx_ff <= scaled;
                     acc_ff <= '0;
                     mcand_ff <= {1'b0, src_y_ff};
                     madd_ff <= PW'(to_screen_ff ? res_y : span_y);
                     divisor_ff <= to_screen_ff ? span_y : res_y;
                     base_ff <= lo_y_ff;
                  end else if (!to_screen_ff) begin
                     ry_ff <= scaled;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Checks on the sequencer and result register.
   property p_no_take_busy;
      @(posedge clock) disable iff (reset)
         (state_ff != mmbt_pkg::ST_IDLE) |-> !rv_ff;
   endproperty
   a_no_take_busy: assert property (p_no_take_busy) else $error("result while busy");

   property p_done_gives;
      @(posedge clock) disable iff (reset)
         (state_ff == mmbt_pkg::ST_DONE) |=> rv_ff;
   endproperty
   a_done_gives: assert property (p_done_gives) else $error("done without result");

   property p_hold;
      @(posedge clock) disable iff (reset)
         (rv_ff && !rsp_ready) |=> rv_ff && $stable(rx_ff) && $stable(rc_ff);
   endproperty
   a_hold: assert property (p_hold) else $error("result changed while stalled");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for mouse_motion_button_tracker_top: random and directed
// packets and queries under several range settings, checked against a local predictor.
// Depends on mmbt_pkg and the block's RTL only.
`timescale 1ns / 1ps
module tb;

   typedef struct {
      mmbt_pkg::kind_type kind;
      logic [7:0]  flags;
      logic [7:0]  dx;
      logic [7:0]  dy;
      logic [15:0] px;
      logic [15:0] py;
      logic [2:0]  bits;
      logic [1:0]  idx;
   } pointer_word_type;

   typedef struct {
      logic [6:0]  events;
      logic [2:0]  buttons;
      logic [15:0] rx;
      logic [15:0] ry;
      logic [15:0] count;
      logic [15:0] mx;
      logic [15:0] my;
      logic        bad;
   } answer_word_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_kind;
   logic [7:0]  req_packet_flags;
   logic [7:0]  req_delta_x_byte;
   logic [7:0]  req_delta_y_byte;
   logic [15:0] req_pos_x;
   logic [15:0] req_pos_y;
   logic [2:0]  req_button_bits;
   logic [1:0]  req_button_index;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [6:0]  rsp_event_mask;
   logic [2:0]  rsp_report_buttons;
   logic [15:0] rsp_report_x;
   logic [15:0] rsp_report_y;
   logic [15:0] rsp_report_count;
   logic signed [15:0] rsp_motion_x;
   logic signed [15:0] rsp_motion_y;
   logic        rsp_bad_index;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   int mismatch_count = 0;
   int words_sent = 0;
   int answers_seen = 0;
   bit long_hold_request = 0;
   bit no_idle = 0;

   mouse_motion_button_tracker_top #(.BUTTON_COUNT(3)) uut (.*);

   // One line per mismatch, and a running count.
   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // Tracker predictor: mirrors the block's state and registers and holds the
   // answers still owed, oldest first.
   class tracker_scoreboard_type;
      logic [15:0] min_x, max_x, min_y, max_y;
      logic [11:0] width, height;
      logic        text;
      logic [15:0] cur_x, cur_y, motion_x, motion_y;
      logic [2:0]  held;
      logic [15:0] press_cnt[3], release_cnt[3];
      logic [31:0] press_at[3], release_at[3];
      answer_word_type owed[$];

      function new();
         min_x = '0; max_x = mmbt_pkg::MAX_X_RESET;
         min_y = '0; max_y = mmbt_pkg::MAX_Y_RESET;
         width = mmbt_pkg::WIDTH_RESET; height = mmbt_pkg::HEIGHT_RESET; text = 1'b1;
         cur_x = '0; cur_y = '0; motion_x = '0; motion_y = '0; held = '0;
         for (int i = 0; i < 3; i++) begin
            press_cnt[i] = '0; release_cnt[i] = '0; press_at[i] = '0; release_at[i] = '0;
         end
      endfunction

      function longint unsigned span(logic [15:0] lo, logic [15:0] hi);
         return (hi >= lo) ? longint'(hi) - longint'(lo) + 1 : 1;
      endfunction

      function longint unsigned resolution(logic [11:0] size);
         longint unsigned r;
         r = text ? longint'(size) * 8 : longint'(size);
         return (r == 0) ? 1 : r;
      endfunction

      function logic [15:0] to_virtual(logic [15:0] p, logic [15:0] lo, logic [15:0] hi,
                                       logic [11:0] size);
         longint unsigned q;
         q = (longint'(p) * span(lo, hi)) / resolution(size);
         return 16'(longint'(lo) + q);
      endfunction

      function logic [15:0] to_screen(logic [15:0] v, logic [15:0] lo, logic [15:0] hi,
                                      logic [11:0] size);
         longint unsigned d;
         d = (v >= lo) ? longint'(v) - longint'(lo) : 0;
         return 16'((d * resolution(size)) / span(lo, hi));
      endfunction

      // Register write, aligned to 8 when text mode is on at write time.
      function void configure(mmbt_pkg::reg_index_type index, logic [15:0] value);
         case (index)
            mmbt_pkg::REG_MIN_X:  min_x = text ? (value & ~mmbt_pkg::ALIGN_BITS) : value;
            mmbt_pkg::REG_MAX_X:  max_x = text ? (value | mmbt_pkg::ALIGN_BITS) : value;
            mmbt_pkg::REG_MIN_Y:  min_y = text ? (value & ~mmbt_pkg::ALIGN_BITS) : value;
            mmbt_pkg::REG_MAX_Y:  max_y = text ? (value | mmbt_pkg::ALIGN_BITS) : value;
            mmbt_pkg::REG_WIDTH:  width = value[11:0];
            mmbt_pkg::REG_HEIGHT: height = value[11:0];
            mmbt_pkg::REG_TEXT:   text = value[0];
            default: ;
         endcase
      endfunction

      // Work out the answer an accepted word causes and queue it.
      function void note_word(pointer_word_type w);
         answer_word_type e;
         logic [15:0] d;
         logic [31:0] spot;
         e = '{default: '0};
         case (w.kind)
            mmbt_pkg::KIND_PACKET: begin
               d = {8'h00, w.dx} - (w.flags[4] ? 16'd256 : 16'd0);
               motion_x = motion_x + d;
               d = {8'h00, w.dy} - (w.flags[5] ? 16'd256 : 16'd0);
               motion_y = motion_y + d;
               cur_x = w.px; cur_y = w.py;
               e.events = mmbt_pkg::MOVED_EVENT;
               for (int i = 0; i < 3; i++) begin
                  if (w.bits[i] && !held[i]) begin
                     press_cnt[i]++;
                     press_at[i] = {cur_y, cur_x};
                     e.events[2*i+1] = 1'b1;
                  end else if (!w.bits[i] && held[i]) begin
                     release_cnt[i]++;
                     release_at[i] = {cur_y, cur_x};
                     e.events[2*i+2] = 1'b1;
                  end
               end
               held = w.bits;
               e.buttons = held;
               e.rx = to_virtual(cur_x, min_x, max_x, width);
               e.ry = to_virtual(cur_y, min_y, max_y, height);
            end
            mmbt_pkg::KIND_READ_POS: begin
               e.buttons = held;
               e.rx = to_virtual(cur_x, min_x, max_x, width);
               e.ry = to_virtual(cur_y, min_y, max_y, height);
            end
            mmbt_pkg::KIND_SET_POS: begin
               cur_x = to_screen(w.px, min_x, max_x, width);
               cur_y = to_screen(w.py, min_y, max_y, height);
            end
            mmbt_pkg::KIND_PRESS, mmbt_pkg::KIND_RELEASE: begin
               e.buttons = held;
               if (w.idx >= 3) begin
                  e.bad = 1'b1;
               end else begin
                  spot = (w.kind == mmbt_pkg::KIND_PRESS) ? press_at[w.idx]
                                                          : release_at[w.idx];
                  e.count = (w.kind == mmbt_pkg::KIND_PRESS) ? press_cnt[w.idx]
                                                             : release_cnt[w.idx];
                  e.rx = to_virtual(spot[15:0], min_x, max_x, width);
                  e.ry = to_virtual(spot[31:16], min_y, max_y, height);
                  if (w.kind == mmbt_pkg::KIND_PRESS) press_cnt[w.idx] = '0;
                  else release_cnt[w.idx] = '0;
               end
            end
            mmbt_pkg::KIND_MOTION: begin
               e.mx = motion_x; e.my = motion_y;
               motion_x = '0; motion_y = '0;
            end
            mmbt_pkg::KIND_RESET: begin
               held = '0; motion_x = '0; motion_y = '0;
               min_x = '0; max_x = mmbt_pkg::MAX_X_RESET;
               min_y = '0; max_y = mmbt_pkg::MAX_Y_RESET;
               for (int i = 0; i < 3; i++) begin
                  press_cnt[i] = '0; release_cnt[i] = '0;
               end
               e.count = 16'd3;
            end
            default: ;
         endcase
         owed.push_back(e);
      endfunction

      // Compare one accepted answer with the oldest one owed.
      task check_answer(answer_word_type got);
         answer_word_type e;
         if (owed.size() == 0) begin
            report_mismatch("answer with none owed");
            return;
         end
         e = owed.pop_front();
         if (got.events !== e.events)
            report_mismatch($sformatf("event_mask %h, want %h", got.events, e.events));
         if (got.buttons !== e.buttons)
            report_mismatch($sformatf("report_buttons %h, want %h", got.buttons, e.buttons));
         if (got.rx !== e.rx)
            report_mismatch($sformatf("report_x %h, want %h", got.rx, e.rx));
         if (got.ry !== e.ry)
            report_mismatch($sformatf("report_y %h, want %h", got.ry, e.ry));
         if (got.count !== e.count)
            report_mismatch($sformatf("report_count %h, want %h", got.count, e.count));
         if (got.mx !== e.mx)
            report_mismatch($sformatf("motion_x %h, want %h", got.mx, e.mx));
         if (got.my !== e.my)
            report_mismatch($sformatf("motion_y %h, want %h", got.my, e.my));
         if (got.bad !== e.bad)
            report_mismatch($sformatf("bad_index %b, want %b", got.bad, e.bad));
      endtask
   endclass

   tracker_scoreboard_type tracker = new();

   // Clock, 8 ns period.
   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   // Answer monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         answers_seen++;
         tracker.check_answer('{rsp_event_mask, rsp_report_buttons, rsp_report_x,
            rsp_report_y, rsp_report_count, rsp_motion_x, rsp_motion_y, rsp_bad_index});
      end
   end

   // Receiver: random stalls, one long hold-off on request.
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_request) begin
            long_hold_request = 0;
            n = 400;
         end else begin
            n = no_idle ? 0 : $urandom_range(0, 3);
         end
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Offer one word and hold it until accepted.
   task automatic send_word(input pointer_word_type w);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= w.kind;
      req_packet_flags <= w.flags;
      req_delta_x_byte <= w.dx;
      req_delta_y_byte <= w.dy;
      req_pos_x <= w.px;
      req_pos_y <= w.py;
      req_button_bits <= w.bits;
      req_button_index <= w.idx;
      do @(posedge clock); while (!req_ready);
      tracker.note_word(w);
      words_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.owed.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input mmbt_pkg::reg_index_type index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.configure(index, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_fields(input mmbt_pkg::kind_type k, input logic [7:0] f,
                              input logic [7:0] dx, input logic [7:0] dy,
                              input logic [15:0] px, input logic [15:0] py,
                              input logic [2:0] b, input logic [1:0] i);
      send_word('{k, f, dx, dy, px, py, b, i});
   endtask

   // Random word; packets dominate so buttons and counters move. Queries favor
   // valid indexes. Motion reads are left out when counters should build up.
   function automatic pointer_word_type random_word(bit keep_motion, int screen_span);
      pointer_word_type w;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) w.kind = mmbt_pkg::KIND_PACKET;
      else if (pick < 53) w.kind = mmbt_pkg::KIND_READ_POS;
      else if (pick < 62) w.kind = mmbt_pkg::KIND_SET_POS;
      else if (pick < 74) w.kind = mmbt_pkg::KIND_PRESS;
      else if (pick < 86) w.kind = mmbt_pkg::KIND_RELEASE;
      else if (pick < 94) w.kind = keep_motion ? mmbt_pkg::KIND_PACKET : mmbt_pkg::KIND_MOTION;
      else if (pick < 97) w.kind = mmbt_pkg::KIND_RESET;
      else w.kind = mmbt_pkg::KIND_NONE;
      w.flags = 8'($urandom_range(0, 255));
      w.dx = 8'($urandom_range(0, 255));
      w.dy = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) begin
         w.px = 16'($urandom_range(0, 65535));
         w.py = 16'($urandom_range(0, 65535));
      end else begin
         w.px = 16'($urandom_range(0, screen_span));
         w.py = 16'($urandom_range(0, screen_span));
      end
      w.bits = 3'($urandom_range(0, 7));
      w.idx = ($urandom_range(0, 5) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      if (keep_motion && w.kind == mmbt_pkg::KIND_PACKET) begin
         w.flags[5:4] = 2'b00;
         w.dx = 8'hFF;
         w.dy = 8'hFF;
      end
      return w;
   endfunction

   task automatic write_all(input logic [15:0] text, input logic [15:0] w,
                            input logic [15:0] h, input logic [15:0] x0,
                            input logic [15:0] x1, input logic [15:0] y0,
                            input logic [15:0] y1);
      write_reg(mmbt_pkg::REG_TEXT, text);
      write_reg(mmbt_pkg::REG_WIDTH, w);
      write_reg(mmbt_pkg::REG_HEIGHT, h);
      write_reg(mmbt_pkg::REG_MIN_X, x0);
      write_reg(mmbt_pkg::REG_MAX_X, x1);
      write_reg(mmbt_pkg::REG_MIN_Y, y0);
      write_reg(mmbt_pkg::REG_MAX_Y, y1);
   endtask

   // Stimulus.
   initial begin
      pointer_word_type w;
      int count;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = mmbt_pkg::KIND_NONE;
      req_packet_flags = '0;
      req_delta_x_byte = '0;
      req_delta_y_byte = '0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_button_bits = '0;
      req_button_index = '0;
      csr_valid = 1'b0;
      csr_index = mmbt_pkg::REG_MIN_X;
      csr_data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words under reset settings.
      send_fields(mmbt_pkg::KIND_PACKET, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 3'b000, 2'd0);
      send_fields(mmbt_pkg::KIND_PACKET, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 3'b111,
                  2'd3);
      send_fields(mmbt_pkg::KIND_PACKET, 8'h30, 8'h00, 8'h01, 16'd320, 16'd100, 3'b010,
                  2'd0);
      send_fields(mmbt_pkg::KIND_PACKET, 8'h10, 8'h80, 8'h7F, 16'd639, 16'd199, 3'b101,
                  2'd0);
      send_fields(mmbt_pkg::KIND_READ_POS, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 3'b000, 2'd0);
      for (int i = 0; i < 4; i++) begin
         send_fields(mmbt_pkg::KIND_PRESS, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 3'b000, 2'(i));
         send_fields(mmbt_pkg::KIND_RELEASE, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 3'b000,
                     2'(i));
      end
      send_fields(mmbt_pkg::KIND_MOTION, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 3'b000, 2'd0);
      send_fields(mmbt_pkg::KIND_SET_POS, 8'h00, 8'h00, 8'h00, 16'd639, 16'd199, 3'b000,
                  2'd0);
      send_fields(mmbt_pkg::KIND_SET_POS, 8'h00, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF, 3'b000,
                  2'd0);
      send_fields(mmbt_pkg::KIND_READ_POS, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 3'b000, 2'd0);
      send_fields(mmbt_pkg::KIND_NONE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 3'b111,
                  2'd3);
      send_fields(mmbt_pkg::KIND_RESET, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 3'b000, 2'd0);
      send_fields(mmbt_pkg::KIND_PRESS, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 3'b000, 2'd2);
      drain();

      // Setting with ranges above the position: set position clamps to screen 0.
      write_all(16'd1, 16'd80, 16'd25, 16'd1000, 16'd1639, 16'd500, 16'd699);
      send_fields(mmbt_pkg::KIND_SET_POS, 8'h00, 8'h00, 8'h00, 16'd10, 16'd20, 3'b000, 2'd0);
      send_fields(mmbt_pkg::KIND_READ_POS, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 3'b000, 2'd0);
      drain();

      // Random phases, each under its own setting.
      for (int phase = 0; phase < 6; phase++) begin
         drain();
         case (phase)
            0: write_all(16'd1, 16'd80, 16'd25, 16'd0, 16'd639, 16'd0, 16'd199);
            1: write_all(16'd0, 16'd640, 16'd480, 16'd0, 16'd639, 16'd0, 16'd479);
            // Inverted ranges and zero screen size.
            2: write_all(16'd0, 16'd0, 16'd0, 16'd900, 16'd100, 16'hFFFF, 16'd0);
            // Wide ranges (full range on y) over the smallest screen: scaled values wrap.
            3: write_all(16'd0, 16'd1, 16'd1, 16'hEA60, 16'hFFFF, 16'd0, 16'hFFFF);
            4: write_all(16'd1, 16'hFFF, 16'hFFF, 16'h1235, 16'hFFF0, 16'd7, 16'd9);
            default: write_all(16'hFFFE, 16'hF123, 16'hF00F, 16'hFFFF, 16'hFFFF,
                               16'd0, 16'd0);
         endcase
         if (phase == 5) write_reg(mmbt_pkg::REG_SPARE, 16'hFFFF);
         no_idle = (phase == 1);
         count = (phase == 3) ? 220 : 185;
         for (int n = 0; n < count; n++) begin
            if (phase == 2 && n == 40) long_hold_request = 1;
            if (phase == 4 && n == 90) drain();
            w = random_word(phase == 3 && n < 200, (phase == 1) ? 700 : 300);
            send_word(w);
         end
         // Motion read after a long run with motion reads held back.
         if (phase == 3)
            send_fields(mmbt_pkg::KIND_MOTION, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 3'b000,
                        2'd0);
      end
      no_idle = 0;
      drain();
      repeat (120) @(posedge clock);
      if (tracker.owed.size() != 0) report_mismatch("answers still owed at end");
      $display("Sent %0d words over seven register settings; %0d answers checked.",
               words_sent, answers_seen);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end
endmodule
